// ----- rtl/tcgr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tcgr_pkg;

    localparam int GLYPH_COUNT_DEF    = 256;
    localparam int GLYPH_BYTES_DEF    = 16;
    localparam int MAX_RESOLUTION_DEF = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int RES_W      = 13;
    localparam int CUR_W      = 12;
    localparam int FW_W       = 4;
    localparam int FH_W       = 5;
    localparam int PITCH_W    = 15;
    localparam int BPP_W      = 3;
    localparam int OFF_W      = 26;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 136;

    localparam logic [CFG_IDX_W-1:0] CFG_X_RES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BPP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COLORS = 3'd7;

    localparam logic [1:0] CMD_PUT    = 2'd0;
    localparam logic [1:0] CMD_LOCATE = 2'd1;
    localparam logic [1:0] CMD_LOAD   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] KIND_ROW    = 2'd0;
    localparam logic [1:0] KIND_SCROLL = 2'd1;
    localparam logic [1:0] KIND_FILL   = 2'd2;

    localparam logic [1:0] FMT_RGB332 = 2'd0;
    localparam logic [1:0] FMT_RGB555 = 2'd1;
    localparam logic [1:0] FMT_RGB565 = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    typedef struct packed {
        logic [1:0]       kind;
        logic [OFF_W-1:0] offset;
        logic [RES_W-1:0] width_px;
        logic [RES_W-1:0] height_px;
        logic [7:0]       pattern;
        logic [31:0]      fg_pixel;
        logic [31:0]      bg_pixel;
        logic [4:0]       scroll_rows;
        logic             last;
    } t_result;

    function automatic logic [31:0] palette(input logic [3:0] idx);
        logic [31:0] c;
        case (idx)
            4'd0:    c = 32'h00000000;
            4'd1:    c = 32'h000000ff;
            4'd2:    c = 32'h0000ff00;
            4'd3:    c = 32'h0000ffff;
            4'd4:    c = 32'h00ff0000;
            4'd5:    c = 32'h00ff00ff;
            4'd6:    c = 32'h00808000;
            4'd7:    c = 32'h00c0c0c0;
            4'd8:    c = 32'h00808080;
            4'd9:    c = 32'h00000080;
            4'd10:   c = 32'h00008080;
            4'd11:   c = 32'h0096A48E;
            4'd12:   c = 32'h00800000;
            4'd13:   c = 32'h00800080;
            4'd14:   c = 32'h00ffff00;
            default: c = 32'h00ffffff;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] pack_pixel(input logic [31:0] c, input logic [1:0] fmt);
        logic [31:0] p;
        case (fmt)
            FMT_RGB332: p = {24'd0, c[23:21], c[15:13], c[7:6]};
            FMT_RGB555: p = {17'd0, c[23:19], c[15:11], c[7:3]};
            FMT_RGB565: p = {16'd0, c[23:19], c[15:10], c[7:3]};
            default:    p = c;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/tcgr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/tcgr_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tcgr_mac (
    input  wire logic [tcgr_pkg::PITCH_W-1:0] i_a,
    input  wire logic [tcgr_pkg::CUR_W-1:0]   i_b,
    input  wire logic [tcgr_pkg::OFF_W-1:0]   i_c,
    output logic      [tcgr_pkg::OFF_W-1:0]   o_p
);
    import tcgr_pkg::*;

    logic [PITCH_W+CUR_W-1:0] prod;

    assign prod = i_a * i_b;
    assign o_p  = prod[OFF_W-1:0] + i_c;
endmodule
`default_nettype wire

// ----- rtl/tcgr_rem.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tcgr_rem (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [tcgr_pkg::RES_W-1:0] i_x,
    input  wire logic [tcgr_pkg::FW_W-1:0]  i_fw,
    input  wire logic [tcgr_pkg::RES_W-1:0] i_y,
    input  wire logic [tcgr_pkg::FH_W-1:0]  i_fh,
    output logic                            o_busy,
    output logic      [tcgr_pkg::FW_W-1:0]  o_rem_x,
    output logic      [tcgr_pkg::FH_W-1:0]  o_rem_y
);
    import tcgr_pkg::*;

    localparam int CNT_W = $clog2(RES_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [RES_W-1:0] r_dx, r_dy;
    logic [FW_W-1:0]  r_rx, tx;
    logic [FH_W-1:0]  r_ry, ty;

    // one quotient bit per cycle, remainder only
    assign tx = {r_rx[FW_W-2:0], r_dx[RES_W-1]};
    assign ty = {r_ry[FH_W-2:0], r_dy[RES_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(RES_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dx <= i_x;
            r_dy <= i_y;
            r_rx <= '0;
            r_ry <= '0;
        end else if (r_cnt != '0) begin
            r_dx <= {r_dx[RES_W-2:0], 1'b0};
            r_dy <= {r_dy[RES_W-2:0], 1'b0};
            r_rx <= (tx >= i_fw) ? tx - i_fw : tx;
            r_ry <= (ty >= i_fh) ? ty - i_fh : ty;
        end
    end

    assign o_busy  = (r_cnt != '0);
    assign o_rem_x = r_rx;
    assign o_rem_y = r_ry;
endmodule
`default_nettype wire

// ----- rtl/text_console_glyph_renderer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  tdata (low bit up)                                  tuser  tlast
// s_*       in         char_code, column, row, font_address, font_byte     cmd    -
// m_*       out        byte_offset, width_px, height_px, pattern,          kind   last
//                      fg_pixel, bg_pixel, scroll_rows
// cfg       in         i_cfg_we / i_cfg_index / i_cfg_data, write only
//
// put character: accept, offset setup in S_MUL and S_MAC on the shared multiply-add, then one
//   glyph row per cycle for the font height while m accepts, and scroll and fill after the
//   last row when the line wraps and scrolls; newline scrolls and fills when it must
// locate waits on the 13-step bit-serial remainder, then clamps the column and row
// synchronous active-low reset restores registers and cursor, font store is not cleared
// a stalled m side holds the sequencer in its emit state
module text_console_glyph_renderer_core #(
    parameter int GLYPH_COUNT    = tcgr_pkg::GLYPH_COUNT_DEF,
    parameter int GLYPH_BYTES    = tcgr_pkg::GLYPH_BYTES_DEF,
    parameter int MAX_RESOLUTION = tcgr_pkg::MAX_RESOLUTION_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tcgr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tcgr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // char_code[7:0], column[19:8], row[31:20], font_address[43:32], font_byte[51:44]
    input  wire logic [tcgr_pkg::IN_DATA_W-1:0]    s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // byte_offset[25:0], width_px[38:26], height_px[51:39], pattern[59:52],
    // fg_pixel[91:60], bg_pixel[123:92], scroll_rows[128:124]
    output logic      [tcgr_pkg::OUT_DATA_W-1:0]   m_tdata,
    // kind[1:0]
    output logic      [1:0]                        m_tuser,
    output logic                                   m_tlast
);
    import tcgr_pkg::*;

    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_MUL      = 11'b00000000010,
        S_MAC      = 11'b00000000100,
        S_ROW      = 11'b00000001000,
        S_SCROLL   = 11'b00000010000,
        S_FILL_MUL = 11'b00000100000,
        S_FILL     = 11'b00001000000,
        S_CLEAR    = 11'b00010000000,
        S_DIV      = 11'b00100000000,
        S_LOC_X    = 11'b01000000000,
        S_LOC_Y    = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    logic [RES_W-1:0]   r_x_res, r_y_res;
    logic [FW_W-1:0]    r_font_w;
    logic [FH_W-1:0]    r_font_h;
    logic [PITCH_W-1:0] r_pitch;
    logic [BPP_W-1:0]   r_bpp;
    logic [1:0]         r_format;
    logic [7:0]         r_colors;

    logic [CUR_W-1:0]   r_cx, n_cx, r_cy, n_cy;
    logic [CUR_W-1:0]   r_col, n_col, r_lrow, n_lrow;
    logic [FH_W-1:0]    r_row, n_row;
    logic [7:0]         r_char, n_char;
    logic [OFF_W-1:0]   r_acc, n_acc;
    logic               r_wrap, n_wrap, r_scroll, n_scroll;

    logic               r_m_valid;
    t_result            r_res, res;
    logic               load, can_load;

    logic [RES_W-1:0]   xr, yr;
    logic [FW_W-1:0]    fw;
    logic [FH_W-1:0]    fh;
    logic [BPP_W-1:0]   bpp;
    logic [31:0]        fg, bg;
    logic [7:0]         mask;

    logic [1:0]         in_cmd;
    logic [7:0]         in_char;
    logic [CUR_W-1:0]   in_col, in_row, in_addr;
    logic [7:0]         in_byte;

    logic [RES_W:0]     x_need, y_need;
    logic               wrap_now, scroll_now;

    logic [PITCH_W-1:0] mac_a;
    logic [CUR_W-1:0]   mac_b;
    logic [OFF_W-1:0]   mac_c, mac_p;

    logic               rem_start, rem_busy;
    logic [FW_W-1:0]    rem_x;
    logic [FH_W-1:0]    rem_y;
    logic [RES_W-1:0]   dx, dy, last_x, last_y;

    logic [8:0]         ch_ext;
    logic [7:0]         ch_mod;
    logic [ADDR_W-1:0]  rd_addr;
    logic               ram_we;
    logic [7:0]         rd_data;

    assign in_cmd  = s_tuser;
    assign in_char = s_tdata[7:0];
    assign in_col  = s_tdata[19:8];
    assign in_row  = s_tdata[31:20];
    assign in_addr = s_tdata[43:32];
    assign in_byte = s_tdata[51:44];

    // saturated register views
    assign xr  = (r_x_res == '0) ? RES_W'(1) :
                 (r_x_res > RES_W'(MAX_RESOLUTION)) ? RES_W'(MAX_RESOLUTION) : r_x_res;
    assign yr  = (r_y_res == '0) ? RES_W'(1) :
                 (r_y_res > RES_W'(MAX_RESOLUTION)) ? RES_W'(MAX_RESOLUTION) : r_y_res;
    assign fw  = (r_font_w == '0) ? FW_W'(1) : (r_font_w > FW_W'(8)) ? FW_W'(8) : r_font_w;
    assign fh  = (r_font_h == '0) ? FH_W'(1) :
                 (r_font_h > FH_W'(GLYPH_BYTES)) ? FH_W'(GLYPH_BYTES) : r_font_h;
    assign bpp = (r_bpp == '0) ? BPP_W'(1) : (r_bpp > BPP_W'(4)) ? BPP_W'(4) : r_bpp;
    assign fg  = pack_pixel(palette(r_colors[3:0]), r_format);
    assign bg  = pack_pixel(palette(r_colors[7:4]), r_format);
    assign mask = ~(8'hff >> fw);

    assign x_need     = (RES_W+1)'(r_cx) + (RES_W+1)'(fw) + (RES_W+1)'(fw);
    assign y_need     = (RES_W+1)'(r_cy) + (RES_W+1)'(fh) + (RES_W+1)'(fh);
    assign wrap_now   = ({1'b0, xr} < x_need);
    assign scroll_now = ({1'b0, yr} < y_need);

    assign dx     = xr - RES_W'(rem_x);
    assign dy     = yr - RES_W'(rem_y);
    assign last_x = (dx >= RES_W'(fw)) ? dx - RES_W'(fw) : '0;
    assign last_y = (dy >= RES_W'(fh)) ? dy - RES_W'(fh) : '0;

    assign ch_ext  = {1'b0, n_char};
    assign ch_mod  = (ch_ext >= 9'(GLYPH_COUNT)) ? 8'(ch_ext - 9'(GLYPH_COUNT)) : n_char;
    assign rd_addr = ADDR_W'(ch_mod) * ADDR_W'(GLYPH_BYTES) + ADDR_W'(n_row);

    assign s_tready = (r_state == S_IDLE);
    assign can_load = !r_m_valid || m_tready;

    always_comb begin
        n_state   = r_state;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_col     = r_col;
        n_lrow    = r_lrow;
        n_row     = r_row;
        n_char    = r_char;
        n_acc     = r_acc;
        n_wrap    = r_wrap;
        n_scroll  = r_scroll;
        load      = 1'b0;
        res       = '0;
        mac_a     = r_pitch;
        mac_b     = CUR_W'(1);
        mac_c     = r_acc;
        rem_start = 1'b0;
        ram_we    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (in_cmd)
                        CMD_PUT: begin
                            if (in_char == CHAR_NEWLINE) begin
                                n_cx = '0;
                                if (scroll_now) begin
                                    n_state = S_SCROLL;
                                end else begin
                                    n_cy = CUR_W'(r_cy + CUR_W'(fh));
                                end
                            end else begin
                                n_char   = in_char;
                                n_row    = '0;
                                n_wrap   = wrap_now;
                                n_scroll = scroll_now;
                                n_state  = S_MUL;
                            end
                        end
                        CMD_LOCATE: begin
                            n_col     = in_col;
                            n_lrow    = in_row;
                            rem_start = 1'b1;
                            n_state   = S_DIV;
                        end
                        CMD_LOAD: begin
                            ram_we = ({1'b0, in_addr} < 13'(STORE_DEPTH));
                        end
                        default: begin
                            n_state = S_CLEAR;
                        end
                    endcase
                end
            end
            S_MUL: begin
                mac_b   = r_cy;
                mac_c   = '0;
                n_acc   = mac_p;
                n_state = S_MAC;
            end
            S_MAC: begin
                mac_a   = PITCH_W'(bpp);
                mac_b   = r_cx;
                n_acc   = mac_p;
                n_state = S_ROW;
            end
            S_ROW: begin
                if (can_load) begin
                    load            = 1'b1;
                    res.kind        = KIND_ROW;
                    res.offset      = r_acc;
                    res.width_px    = RES_W'(fw);
                    res.height_px   = RES_W'(1);
                    res.pattern     = rd_data & mask;
                    res.fg_pixel    = fg;
                    res.bg_pixel    = bg;
                    res.last        = (r_row == fh - 1'b1) && !(r_wrap && r_scroll);
                    n_acc           = mac_p;
                    if (r_row == fh - 1'b1) begin
                        if (r_wrap) begin
                            n_cx = '0;
                            if (r_scroll) begin
                                n_state = S_SCROLL;
                            end else begin
                                n_cy    = CUR_W'(r_cy + CUR_W'(fh));
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_cx    = CUR_W'(r_cx + CUR_W'(fw));
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            S_SCROLL: begin
                if (can_load) begin
                    load            = 1'b1;
                    res.kind        = KIND_SCROLL;
                    res.height_px   = RES_W'(r_cy);
                    res.scroll_rows = fh;
                    n_state         = S_FILL_MUL;
                end
            end
            S_FILL_MUL: begin
                mac_b   = r_cy;
                mac_c   = '0;
                n_acc   = mac_p;
                n_state = S_FILL;
            end
            S_FILL: begin
                if (can_load) begin
                    load          = 1'b1;
                    res.kind      = KIND_FILL;
                    res.offset    = r_acc;
                    res.width_px  = xr;
                    res.height_px = RES_W'(fh);
                    res.bg_pixel  = bg;
                    res.last      = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (can_load) begin
                    load          = 1'b1;
                    res.kind      = KIND_FILL;
                    res.width_px  = xr;
                    res.height_px = yr;
                    res.bg_pixel  = bg;
                    res.last      = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_DIV: begin
                if (!rem_busy) begin
                    n_state = S_LOC_X;
                end
            end
            S_LOC_X: begin
                mac_a   = PITCH_W'(fw);
                mac_b   = r_col;
                mac_c   = OFF_W'(fw);
                n_cx    = (mac_p <= OFF_W'(xr)) ? CUR_W'(mac_p - OFF_W'(fw)) : last_x[CUR_W-1:0];
                n_state = S_LOC_Y;
            end
            S_LOC_Y: begin
                mac_a   = PITCH_W'(fh);
                mac_b   = r_lrow;
                mac_c   = OFF_W'(fh);
                n_cy    = (mac_p <= OFF_W'(yr)) ? CUR_W'(mac_p - OFF_W'(fh)) : last_y[CUR_W-1:0];
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cx      <= '0;
            r_cy      <= '0;
            r_m_valid <= 1'b0;
            r_x_res   <= RES_W'(640);
            r_y_res   <= RES_W'(480);
            r_font_w  <= FW_W'(8);
            r_font_h  <= FH_W'(16);
            r_pitch   <= PITCH_W'(2560);
            r_bpp     <= BPP_W'(4);
            r_format  <= 2'd3;
            r_colors  <= 8'd15;
        end else begin
            r_state   <= n_state;
            r_cx      <= n_cx;
            r_cy      <= n_cy;
            r_m_valid <= load ? 1'b1 : (m_tready ? 1'b0 : r_m_valid);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_X_RES:  r_x_res  <= i_cfg_data[RES_W-1:0];
                    CFG_Y_RES:  r_y_res  <= i_cfg_data[RES_W-1:0];
                    CFG_FONT_W: r_font_w <= i_cfg_data[FW_W-1:0];
                    CFG_FONT_H: r_font_h <= i_cfg_data[FH_W-1:0];
                    CFG_PITCH:  r_pitch  <= i_cfg_data[PITCH_W-1:0];
                    CFG_BPP:    r_bpp    <= i_cfg_data[BPP_W-1:0];
                    CFG_FORMAT: r_format <= i_cfg_data[1:0];
                    CFG_COLORS: r_colors <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col    <= n_col;
        r_lrow   <= n_lrow;
        r_row    <= n_row;
        r_char   <= n_char;
        r_acc    <= n_acc;
        r_wrap   <= n_wrap;
        r_scroll <= n_scroll;
        if (load) begin
            r_res <= res;
        end
    end

    tcgr_mac u_mac (
        .i_a (mac_a),
        .i_b (mac_b),
        .i_c (mac_c),
        .o_p (mac_p)
    );

    tcgr_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rem_start),
        .i_x     (xr),
        .i_fw    (fw),
        .i_y     (yr),
        .i_fh    (fh),
        .o_busy  (rem_busy),
        .o_rem_x (rem_x),
        .o_rem_y (rem_y)
    );

    tcgr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (in_addr[ADDR_W-1:0]),
        .i_wdata (in_byte),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign m_tvalid = r_m_valid;
    assign m_tuser  = r_res.kind;
    assign m_tlast  = r_res.last;
    assign m_tdata  = {7'd0, r_res.scroll_rows, r_res.bg_pixel, r_res.fg_pixel,
                       r_res.pattern, r_res.height_px, r_res.width_px, r_res.offset};
endmodule
`default_nettype wire

// ----- rtl/tcgr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tcgr_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [tcgr_pkg::IN_DATA_W-1:0]  s_tdata,
    input wire logic [1:0]                      s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [tcgr_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic [1:0]                      m_tuser,
    input wire logic                            m_tlast
);
    import tcgr_pkg::*;

    // held result while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("bad result kind");

    a_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == KIND_ROW |-> m_tdata[51:39] == 13'd1 && m_tdata[128:124] == 5'd0)
        else $error("glyph row with bad height or scroll count");

    a_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == KIND_SCROLL |-> !m_tlast)
        else $error("scroll marked as final transfer");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tuser == CMD_PUT && s_tdata[7:0] != CHAR_NEWLINE
        |=> !s_tready)
        else $error("ready right after a glyph transfer");
endmodule

bind text_console_glyph_renderer_core tcgr_checker u_tcgr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import tcgr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 40;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 26;
    localparam int STORE_DEPTH = GLYPH_COUNT_DEF * GLYPH_BYTES_DEF;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  ch;
        logic [11:0] col;
        logic [11:0] rw;
        logic [11:0] adr;
        logic [7:0]  fb;
        bit          typed;
        logic [1:0]  kind;
        logic [25:0] off;
        logic [12:0] w;
        logic [12:0] h;
        logic [31:0] bg;
    } t_probe;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    text_console_glyph_renderer_core dut (.*);

    always #6 i_clk = ~i_clk;

    // expected draw commands, oldest first
    t_result draw_cmds_due[$];
    int unsigned cfg_reg [8];
    int unsigned cur_x, cur_y;
    logic [7:0]  glyph_bytes [STORE_DEPTH];
    bit          glyph_set [STORE_DEPTH];
    logic [7:0]  seed_glyphs [8] = '{8'h00, 8'h01, 8'h41, 8'h55, 8'h7f, 8'h80, 8'haa, 8'hff};
    logic [31:0] colors [16] = '{
        32'h00000000, 32'h000000ff, 32'h0000ff00, 32'h0000ffff,
        32'h00ff0000, 32'h00ff00ff, 32'h00808000, 32'h00c0c0c0,
        32'h00808080, 32'h00000080, 32'h00008080, 32'h0096A48E,
        32'h00800000, 32'h00800080, 32'h00ffff00, 32'h00ffffff};

    int unsigned phase_cfg [PHASES][8] = '{
        '{640, 480, 8, 16, 2560, 4, 3, 15},
        '{4096, 4096, 1, 1, 16384, 1, 0, 8'ha5},
        '{1, 1, 8, 16, 1, 0, 1, 8'hff},
        '{8191, 0, 15, 31, 32767, 7, 2, 8'h00},
        '{100, 60, 6, 9, 300, 3, 3, 8'h3c},
        '{64, 48, 8, 8, 64, 2, 1, 8'hb7}};

    t_probe probes [16] = '{
        '{CMD_CLEAR, 0, 0, 0, 0, 0, 1, KIND_FILL, 0, 640, 480, 0},
        '{CMD_PUT, 8'h41, 0, 0, 0, 0, 1, KIND_ROW, 0, 8, 1, 0},
        '{CMD_LOCATE, 0, 4095, 4095, 0, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PUT, 8'hff, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PUT, CHAR_NEWLINE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_LOCATE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PUT, 8'h00, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PUT, 8'h55, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PUT, 8'haa, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PUT, 8'h80, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PUT, 8'h01, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PUT, 8'h7f, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PUT, CHAR_NEWLINE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_LOAD, 0, 0, 0, 4095, 8'hff, 0, 0, 0, 0, 0, 0},
        '{CMD_LOAD, 0, 0, 0, 0, 8'h00, 0, 0, 0, 0, 0, 0},
        '{CMD_CLEAR, 0, 0, 0, 0, 0, 1, KIND_FILL, 0, 640, 480, 0}};

    int  idle_pct, stall_pct, cycles, mismatches, directed_bad, results_seen, items_sent;
    int  hold_left = 0;
    bit  long_hold_req;

    function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [31:0] pixel_pack(logic [31:0] c);
        case (cfg_reg[CFG_FORMAT] & 3)
            FMT_RGB332: return ((c >> 16) & 32'he0) | ((c >> 11) & 32'h1c) | ((c >> 6) & 32'h03);
            FMT_RGB555: return ((c >> 9) & 32'h7c00) | ((c >> 6) & 32'h03e0)
                               | ((c >> 3) & 32'h001f);
            FMT_RGB565: return ((c >> 8) & 32'hf800) | ((c >> 5) & 32'h07e0)
                               | ((c >> 3) & 32'h001f);
            default:    return c;
        endcase
    endfunction

    function automatic void push_cmd(logic [1:0] k, int unsigned off, int unsigned w,
                                     int unsigned h, int unsigned pat, logic [31:0] fg,
                                     logic [31:0] bg, int unsigned rows);
        t_result e;
        e.kind        = k;
        e.offset      = off[25:0];
        e.width_px    = w[12:0];
        e.height_px   = h[12:0];
        e.pattern     = pat[7:0];
        e.fg_pixel    = fg;
        e.bg_pixel    = bg;
        e.scroll_rows = rows[4:0];
        e.last        = 1'b0;
        draw_cmds_due.push_back(e);
    endfunction

    function automatic void line_feed(int unsigned xr, int unsigned yr, int unsigned fh);
        int unsigned y;
        y = cur_y + fh;
        cur_x = 0;
        if (yr < y + fh) begin
            y -= fh;
            push_cmd(KIND_SCROLL, 0, 0, y, 0, 0, 0, fh);
            push_cmd(KIND_FILL, cfg_reg[CFG_PITCH] * y, xr, fh, 0, 0,
                     pixel_pack(colors[(cfg_reg[CFG_COLORS] >> 4) & 15]), 0);
        end
        cur_y = y & 12'hfff;
    endfunction

    function automatic void predict_draw_cmds(logic [1:0] c, logic [IN_DATA_W-1:0] d);
        int unsigned xr, yr, fw, fh, bpp, base, msk, x, cols, rws, cc, rr, n0;
        logic [31:0] fg, bg;
        xr  = clip(cfg_reg[CFG_X_RES], 1, MAX_RESOLUTION_DEF);
        yr  = clip(cfg_reg[CFG_Y_RES], 1, MAX_RESOLUTION_DEF);
        fw  = clip(cfg_reg[CFG_FONT_W], 1, 8);
        fh  = clip(cfg_reg[CFG_FONT_H], 1, GLYPH_BYTES_DEF);
        bpp = clip(cfg_reg[CFG_BPP], 1, 4);
        fg  = pixel_pack(colors[cfg_reg[CFG_COLORS] & 15]);
        bg  = pixel_pack(colors[(cfg_reg[CFG_COLORS] >> 4) & 15]);
        n0  = draw_cmds_due.size();
        case (c)
            CMD_PUT: begin
                if (d[7:0] == CHAR_NEWLINE) begin
                    line_feed(xr, yr, fh);
                end else begin
                    base = d[7:0] * GLYPH_BYTES_DEF;
                    msk  = (32'hff << (8 - fw)) & 32'hff;
                    for (int r = 0; r < fh; r++)
                        push_cmd(KIND_ROW, cfg_reg[CFG_PITCH] * (cur_y + r) + bpp * cur_x,
                                 fw, 1, glyph_bytes[(base + r) % STORE_DEPTH] & msk,
                                 fg, bg, 0);
                    x = cur_x + fw;
                    cur_x = x & 12'hfff;
                    if (xr < x + fw)
                        line_feed(xr, yr, fh);
                end
            end
            CMD_LOCATE: begin
                cols = xr / fw;
                rws  = yr / fh;
                if (cols == 0) cols = 1;
                if (rws == 0) rws = 1;
                cc = d[19:8];
                rr = d[31:20];
                if (cc >= cols) cc = cols - 1;
                if (rr >= rws) rr = rws - 1;
                cur_x = (cc * fw) & 12'hfff;
                cur_y = (rr * fh) & 12'hfff;
            end
            CMD_LOAD: begin
                if (d[43:32] < STORE_DEPTH) begin
                    glyph_bytes[d[43:32]] = d[51:44];
                    glyph_set[d[43:32]]   = 1'b1;
                end
            end
            default: push_cmd(KIND_FILL, 0, xr, yr, 0, 0, bg, 0);
        endcase
        if (draw_cmds_due.size() > n0)
            draw_cmds_due[draw_cmds_due.size()-1].last = 1'b1;
    endfunction

    function automatic bit glyph_ready(logic [7:0] ch);
        for (int r = 0; r < GLYPH_BYTES_DEF; r++)
            if (!glyph_set[ch * GLYPH_BYTES_DEF + r]) return 0;
        return 1;
    endfunction

    function automatic logic [IN_DATA_W-1:0] item_data(logic [7:0] ch, logic [11:0] col,
                                                       logic [11:0] rw, logic [11:0] adr,
                                                       logic [7:0] fb);
        return {4'd0, fb, adr, rw, col, ch};
    endfunction

    task automatic send_item(logic [1:0] c, logic [IN_DATA_W-1:0] d);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= d;
        do @(posedge i_clk); while (!s_tready);
        predict_draw_cmds(c, d);
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (draw_cmds_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(int unsigned v [8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= i[CFG_IDX_W-1:0];
            i_cfg_data  <= v[i][CFG_DATA_W-1:0];
            cfg_reg[i]   = v[i] & 32'h7fff;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_item();
        logic [IN_DATA_W-1:0] d;
        logic [7:0]           ch;
        int                   sel;
        d   = IN_DATA_W'({$urandom, $urandom});
        d[55:52] = 4'd0;
        sel = $urandom_range(99);
        if (sel < 10) begin
            d[7:0] = CHAR_NEWLINE;
            send_item(CMD_PUT, d);
        end else if (sel < 65) begin
            ch = seed_glyphs[$urandom_range(7)];
            repeat (6) begin
                d[7:0] = 8'($urandom_range(255));
                if (d[7:0] != CHAR_NEWLINE && glyph_ready(d[7:0])) ch = d[7:0];
            end
            d[7:0] = ch;
            send_item(CMD_PUT, d);
        end else if (sel < 82) begin
            if ($urandom_range(1)) begin
                d[19:8]  = 12'($urandom_range(40));
                d[31:20] = 12'($urandom_range(40));
            end
            send_item(CMD_LOCATE, d);
        end else if (sel < 95) begin
            send_item(CMD_LOAD, d);
        end else begin
            send_item(CMD_CLEAR, d);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (long_hold_req && hold_left == 0) begin
            hold_left <= 400;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= (hold_left == 1);
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (draw_cmds_due.size() == 0) begin
                mismatches++;
                if (mismatches + directed_bad <= 10)
                    $display("unexpected transfer: kind %0d data %h", m_tuser, m_tdata);
            end else begin
                e = draw_cmds_due.pop_front();
                if (m_tuser !== e.kind || m_tdata[25:0] !== e.offset
                        || m_tdata[38:26] !== e.width_px || m_tdata[51:39] !== e.height_px
                        || m_tdata[59:52] !== e.pattern || m_tdata[91:60] !== e.fg_pixel
                        || m_tdata[123:92] !== e.bg_pixel
                        || m_tdata[128:124] !== e.scroll_rows || m_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches + directed_bad <= 10)
                        $display({"bad transfer: exp kind %0d off %h w %0d h %0d pat %h ",
                                  "fg %h bg %h rows %0d last %b / got %0d %h %0d %0d %h ",
                                  "%h %h %0d %b"},
                                 e.kind, e.offset, e.width_px, e.height_px, e.pattern,
                                 e.fg_pixel, e.bg_pixel, e.scroll_rows, e.last,
                                 m_tuser, m_tdata[25:0], m_tdata[38:26], m_tdata[51:39],
                                 m_tdata[59:52], m_tdata[91:60], m_tdata[123:92],
                                 m_tdata[128:124], m_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("text_console_glyph_renderer_core: mismatch");
            $finish;
        end
    end

    initial begin
        int unsigned n0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= CMD_PUT;
        idle_pct = 0;
        stall_pct = 0;
        directed_bad = 0;
        long_hold_req = 0;
        cfg_reg = phase_cfg[0];
        cur_x = 0;
        cur_y = 0;
        foreach (glyph_set[i]) glyph_set[i] = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (seed_glyphs[g])
            for (int r = 0; r < GLYPH_BYTES_DEF; r++)
                send_item(CMD_LOAD, item_data(0, 0, 0,
                                              12'(seed_glyphs[g] * GLYPH_BYTES_DEF + r),
                                              (r == 0) ? 8'hff : (r == 1) ? 8'h00
                                              : 8'($urandom)));

        foreach (probes[p]) begin
            n0 = draw_cmds_due.size();
            send_item(probes[p].cmd, item_data(probes[p].ch, probes[p].col, probes[p].rw,
                                               probes[p].adr, probes[p].fb));
            if (probes[p].typed && (draw_cmds_due.size() <= n0
                    || draw_cmds_due[n0].kind !== probes[p].kind
                    || draw_cmds_due[n0].offset !== probes[p].off
                    || draw_cmds_due[n0].width_px !== probes[p].w
                    || draw_cmds_due[n0].height_px !== probes[p].h
                    || draw_cmds_due[n0].bg_pixel !== probes[p].bg)) begin
                directed_bad++;
                if (mismatches + directed_bad <= 10)
                    $display("directed row %0d: wrong first command", p);
            end
        end
        drain_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            idle_pct  = (ph % 4 == 1) ? 47 : (ph % 4 == 3) ? 22 : 0;
            stall_pct = (ph % 4 == 2) ? 47 : (ph % 4 == 3) ? 22 : 0;
            write_regs(phase_cfg[ph]);
            if (ph == 2) long_hold_req = 1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == 5) long_hold_req = 0;
                if (ph == 1 && k == 25) drain_results();
                random_item();
            end
            drain_results();
        end

        $display("covered %0d input items and %0d draw commands over %0d register settings",
                 items_sent, results_seen, PHASES + 1);
        $display("all four pixel formats, clamped registers, wraps, scrolls and clears seen");
        if (mismatches == 0 && directed_bad == 0 && draw_cmds_due.size() == 0) begin
            $display("text_console_glyph_renderer_core: match");
        end else begin
            $display("text_console_glyph_renderer_core: mismatch");
        end
        $finish;
    end
endmodule
